[rtl/haar_feature_eval_unit_assert.svh]
// ----------------------------------------------------------------------------
// Haar feature evaluator assertion macros
// Clocked assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef HAAR_FEATURE_EVAL_UNIT_ASSERT_SVH
`define HAAR_FEATURE_EVAL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define HFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true out of reset
`define HFE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define HFE_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/hfe_pkg.sv]
// ----------------------------------------------------------------------------
// Haar feature evaluator package
// Field widths, codes, corner term table and offset helpers.
// ----------------------------------------------------------------------------
package hfe_pkg;

    localparam int OUT_W      = 29;
    localparam int ROW_W      = 13;
    localparam int ADDR_IN_W  = 12;
    localparam int LOAD_W     = 24;
    localparam int TYPE_W     = 3;
    localparam int SPAN_W     = 6;
    localparam int K_W        = 4;
    localparam int OFF_W      = 8;
    localparam int TERM_COUNT = 9;

    localparam int OUT_MAX = 268435455;
    localparam int OUT_MIN = -268435456;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 13'd64;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [TYPE_W-1:0] FT_HORIZ2 = 3'd1;
    localparam logic [TYPE_W-1:0] FT_HORIZ3 = 3'd2;
    localparam logic [TYPE_W-1:0] FT_VERT2  = 3'd3;
    localparam logic [TYPE_W-1:0] FT_VERT3  = 3'd4;
    localparam logic [TYPE_W-1:0] FT_CHECK  = 3'd5;

    // corner offset selectors: -1, full span, half, third, two thirds
    typedef enum logic [2:0] {
        OFF_NEG,
        OFF_FULL,
        OFF_HALF,
        OFF_THIRD,
        OFF_TWO3
    } t_off_code;

    typedef struct packed {
        t_off_code          xc;
        t_off_code          yc;
        logic signed [3:0]  wt;
    } t_term;

    function automatic t_term mk_term(input t_off_code xc, input t_off_code yc,
                                      input logic signed [3:0] wt);
        t_term t;
        t.xc = xc;
        t.yc = yc;
        t.wt = wt;
        return t;
    endfunction

    // floor(x / 3) for x <= 126, via reciprocal 171 / 512
    function automatic logic [SPAN_W-1:0] div3(input logic [SPAN_W:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd171;
        return p[14:9];
    endfunction

    function automatic logic signed [OFF_W-1:0] offset_of(input t_off_code code,
                                                          input logic [SPAN_W-1:0] span);
        logic signed [OFF_W-1:0] r;
        case (code)
            OFF_FULL:  r = signed'({2'b00, span});
            OFF_HALF:  r = signed'({3'b000, span[SPAN_W-1:1]});
            OFF_THIRD: r = signed'({2'b00, div3({1'b0, span})});
            OFF_TWO3:  r = signed'({2'b00, div3({span, 1'b0})});
            default:   r = -8'sd1;
        endcase
        return r;
    endfunction

    // corner terms per feature; weight zero marks an empty slot
    function automatic t_term term_of(input logic [TYPE_W-1:0] ft,
                                      input logic [K_W-1:0] k);
        t_term t;
        t = mk_term(OFF_NEG, OFF_NEG, 4'sd0);
        case (ft)
            FT_HORIZ2: begin
                case (k)
                    4'd0: t = mk_term(OFF_HALF, OFF_FULL, 4'sd2);
                    4'd1: t = mk_term(OFF_FULL, OFF_FULL, -4'sd1);
                    4'd2: t = mk_term(OFF_FULL, OFF_NEG,  4'sd1);
                    4'd3: t = mk_term(OFF_HALF, OFF_NEG,  -4'sd2);
                    4'd4: t = mk_term(OFF_NEG,  OFF_FULL, -4'sd1);
                    4'd5: t = mk_term(OFF_NEG,  OFF_NEG,  4'sd1);
                    default: ;
                endcase
            end
            FT_HORIZ3: begin
                case (k)
                    4'd0: t = mk_term(OFF_FULL,  OFF_FULL, 4'sd1);
                    4'd1: t = mk_term(OFF_TWO3,  OFF_FULL, -4'sd2);
                    4'd2: t = mk_term(OFF_THIRD, OFF_FULL, 4'sd2);
                    4'd3: t = mk_term(OFF_FULL,  OFF_NEG,  -4'sd1);
                    4'd4: t = mk_term(OFF_TWO3,  OFF_NEG,  4'sd2);
                    4'd5: t = mk_term(OFF_THIRD, OFF_NEG,  -4'sd2);
                    4'd6: t = mk_term(OFF_NEG,   OFF_FULL, -4'sd1);
                    4'd7: t = mk_term(OFF_NEG,   OFF_NEG,  4'sd1);
                    default: ;
                endcase
            end
            FT_VERT2: begin
                case (k)
                    4'd0: t = mk_term(OFF_FULL, OFF_HALF, 4'sd2);
                    4'd1: t = mk_term(OFF_FULL, OFF_FULL, -4'sd1);
                    4'd2: t = mk_term(OFF_FULL, OFF_NEG,  -4'sd1);
                    4'd3: t = mk_term(OFF_NEG,  OFF_FULL, 4'sd1);
                    4'd4: t = mk_term(OFF_NEG,  OFF_HALF, -4'sd2);
                    4'd5: t = mk_term(OFF_NEG,  OFF_NEG,  4'sd1);
                    default: ;
                endcase
            end
            FT_VERT3: begin
                case (k)
                    4'd0: t = mk_term(OFF_FULL, OFF_FULL,  4'sd1);
                    4'd1: t = mk_term(OFF_FULL, OFF_TWO3,  -4'sd2);
                    4'd2: t = mk_term(OFF_FULL, OFF_THIRD, 4'sd2);
                    4'd3: t = mk_term(OFF_NEG,  OFF_FULL,  -4'sd1);
                    4'd4: t = mk_term(OFF_NEG,  OFF_TWO3,  4'sd2);
                    4'd5: t = mk_term(OFF_NEG,  OFF_THIRD, -4'sd2);
                    4'd6: t = mk_term(OFF_FULL, OFF_NEG,   -4'sd1);
                    4'd7: t = mk_term(OFF_NEG,  OFF_NEG,   4'sd1);
                    default: ;
                endcase
            end
            FT_CHECK: begin
                case (k)
                    4'd0: t = mk_term(OFF_FULL, OFF_FULL, 4'sd1);
                    4'd1: t = mk_term(OFF_HALF, OFF_FULL, -4'sd2);
                    4'd2: t = mk_term(OFF_FULL, OFF_HALF, -4'sd2);
                    4'd3: t = mk_term(OFF_HALF, OFF_HALF, 4'sd4);
                    4'd4: t = mk_term(OFF_NEG,  OFF_FULL, 4'sd1);
                    4'd5: t = mk_term(OFF_NEG,  OFF_HALF, -4'sd2);
                    4'd6: t = mk_term(OFF_FULL, OFF_NEG,  4'sd1);
                    4'd7: t = mk_term(OFF_HALF, OFF_NEG,  -4'sd2);
                    4'd8: t = mk_term(OFF_NEG,  OFF_NEG,  4'sd1);
                    default: ;
                endcase
            end
            default: ;
        endcase
        return t;
    endfunction

endpackage

[rtl/haar_feature_eval_unit.sv]
// ----------------------------------------------------------------------------
// Haar feature evaluation unit
// Integral-image store with a corner-sum sequencer for five Haar-like features.
// ----------------------------------------------------------------------------
// A load transfer writes one integral-image word into a single-port memory;
// loads to an address at or past MEM_DEPTH are dropped. An evaluate transfer
// stalls the input until the unit is idle again: a bit-serial remainder
// (origin mod row width) that decides whether the left column exists, 9 term
// slots that each compute one corner address and read it through the
// memory's single read port, a drain while the address/read/accumulate
// pipeline empties and a last step that hands the sum to the output register.
// The output register parts the two sides, so a new transfer is taken while a
// result still waits, though a second evaluation waits in its last step until
// that register frees. Reading a word that was never loaded returns whatever
// the memory holds. The user must write row width on the config channel only
// while the unit is idle; the unit does not enforce it. Zero width acts as one.
// ----------------------------------------------------------------------------
`include "haar_feature_eval_unit_assert.svh"

module haar_feature_eval_unit #(
    parameter int MEM_DEPTH  = 4096,
    parameter int VALUE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hfe_pkg::ROW_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [hfe_pkg::ADDR_IN_W-1:0]       i_load_address,
    input  logic [hfe_pkg::LOAD_W-1:0]          i_load_value,
    input  logic [hfe_pkg::TYPE_W-1:0]          i_feature_type,
    input  logic [hfe_pkg::SPAN_W-1:0]          i_feature_w,
    input  logic [hfe_pkg::SPAN_W-1:0]          i_feature_h,
    input  logic [hfe_pkg::ADDR_IN_W-1:0]       i_origin_index,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [hfe_pkg::OUT_W-1:0]    o_feature_value,
    output logic                                o_address_error
);

    localparam int AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LDW   = 17;                      // holds MEM_DEPTH up to 131071
    localparam int IDX_W = 22;                      // signed corner index
    localparam int ACC_W = VALUE_BITS + 5;
    localparam int SAT_W = (ACC_W > hfe_pkg::OUT_W + 1) ? ACC_W : hfe_pkg::OUT_W + 1;
    localparam logic [hfe_pkg::K_W-1:0] K_LAST = hfe_pkg::K_W'(hfe_pkg::TERM_COUNT - 1);
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(hfe_pkg::OUT_MAX);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(hfe_pkg::OUT_MIN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TERM,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state                               r_state;
    logic [hfe_pkg::ROW_W-1:0]            r_row_width;
    logic [hfe_pkg::ROW_W-1:0]            r_stride;
    logic [hfe_pkg::TYPE_W-1:0]           r_ftype;
    logic [hfe_pkg::SPAN_W-1:0]           r_w;
    logic [hfe_pkg::SPAN_W-1:0]           r_h;
    logic [hfe_pkg::ADDR_IN_W-1:0]        r_ori;
    logic                                 r_has_top;
    logic                                 r_has_left;
    logic [hfe_pkg::ROW_W-1:0]            r_rem;
    logic [3:0]                           r_bit;
    logic [hfe_pkg::K_W-1:0]              r_k;
    logic                                 r_p1_valid;
    logic signed [IDX_W-1:0]              r_p1_idx;
    logic signed [3:0]                    r_p1_wt;
    logic                                 r_p2_valid;
    logic signed [3:0]                    r_p2_wt;
    logic [VALUE_BITS-1:0]                r_rd_data;
    logic signed [ACC_W-1:0]              r_acc;
    logic                                 r_err;
    logic                                 r_out_valid;
    logic signed [hfe_pkg::OUT_W-1:0]     r_out_value;
    logic                                 r_out_err;

    logic [VALUE_BITS-1:0]                mem [MEM_DEPTH];

    logic                                 in_acc;
    logic                                 cfg_we;
    logic                                 out_free;
    logic [LDW-1:0]                       ld_ext;
    logic                                 ld_in_range;
    logic                                 mem_we;
    logic [31:0]                          ld_val_ext;
    logic [hfe_pkg::ROW_W-1:0]            stride_in;
    logic [hfe_pkg::ROW_W:0]              rem_sh;
    logic [hfe_pkg::ROW_W-1:0]            rem_next;
    hfe_pkg::t_term                       cur_term;
    logic signed [hfe_pkg::OFF_W-1:0]     xoff;
    logic signed [hfe_pkg::OFF_W-1:0]     yoff;
    logic signed [IDX_W-1:0]              row_off;
    logic signed [IDX_W-1:0]              idx;
    logic                                 term_active;
    logic                                 in_range;
    logic                                 rd_en;
    logic signed [ACC_W-1:0]              dext;
    logic signed [ACC_W-1:0]              term_val;
    logic signed [SAT_W-1:0]              acc_ext;
    logic signed [hfe_pkg::OUT_W-1:0]     sat_val;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_feature_value = r_out_value;
    assign o_address_error = r_out_err;

    // load path
    assign ld_ext      = LDW'(i_load_address);
    assign ld_in_range = ld_ext < LDW'(MEM_DEPTH);
    assign mem_we      = in_acc && (i_operation == hfe_pkg::OP_LOAD) && ld_in_range;
    assign ld_val_ext  = 32'(i_load_value);

    // setup
    assign stride_in = (r_row_width == '0) ? hfe_pkg::ROW_W'(1) : r_row_width;

    // one restoring remainder step per cycle, MSB of origin first
    assign rem_sh   = {r_rem, r_ori[r_bit]};
    assign rem_next = (rem_sh >= {1'b0, r_stride})
                    ? hfe_pkg::ROW_W'(rem_sh - {1'b0, r_stride})
                    : rem_sh[hfe_pkg::ROW_W-1:0];

    // stage 1: corner address for term r_k
    assign cur_term = hfe_pkg::term_of(r_ftype, r_k);
    assign xoff     = hfe_pkg::offset_of(cur_term.xc, r_w);
    assign yoff     = hfe_pkg::offset_of(cur_term.yc, r_h);
    assign row_off  = yoff * $signed({1'b0, r_stride});
    assign idx      = $signed(IDX_W'(r_ori)) + IDX_W'(xoff) + row_off;

    // a term above the top row or left of column zero is dropped, not an error
    assign term_active = (r_state == S_TERM) && (cur_term.wt != 4'sd0)
                       && !((cur_term.yc == hfe_pkg::OFF_NEG) && !r_has_top)
                       && !((cur_term.xc == hfe_pkg::OFF_NEG) && !r_has_left);

    // stage 2: bounds check and memory read
    assign in_range = !r_p1_idx[IDX_W-1]
                    && (r_p1_idx[IDX_W-2:0] < (IDX_W-1)'(MEM_DEPTH));
    assign rd_en    = r_p1_valid && in_range;

    // stage 3: weight is a small power of two, so shift and negate
    assign dext = signed'(ACC_W'(r_rd_data));

    always_comb begin
        case (r_p2_wt)
            4'sd1:   term_val = dext;
            -4'sd1:  term_val = -dext;
            4'sd2:   term_val = dext <<< 1;
            -4'sd2:  term_val = -(dext <<< 1);
            4'sd4:   term_val = dext <<< 2;
            default: term_val = '0;
        endcase
    end

    // clamp to the output range
    assign acc_ext = SAT_W'(r_acc);

    always_comb begin
        if (acc_ext > SAT_MAX) begin
            sat_val = hfe_pkg::OUT_W'(SAT_MAX);
        end else if (acc_ext < SAT_MIN) begin
            sat_val = hfe_pkg::OUT_W'(SAT_MIN);
        end else begin
            sat_val = hfe_pkg::OUT_W'(acc_ext);
        end
    end

    // image store: single port, loads only in idle, reads only while summing
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[ld_ext[AW-1:0]] <= ld_val_ext[VALUE_BITS-1:0];
        end
        if (rd_en) begin
            r_rd_data <= mem[r_p1_idx[AW-1:0]];
        end
    end

    // sequencer, pipeline and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_width <= hfe_pkg::ROW_WIDTH_RESET;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_row_width <= i_cfg_data;
            end

            r_p1_valid <= 1'b0;
            r_p2_valid <= rd_en;
            r_p2_wt    <= r_p1_wt;
            if (r_p1_valid && !in_range) begin
                r_err <= 1'b1;
            end
            if (r_p2_valid) begin
                r_acc <= r_acc + term_val;
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_operation == hfe_pkg::OP_EVAL)) begin
                        r_ftype   <= i_feature_type;
                        r_w       <= i_feature_w;
                        r_h       <= i_feature_h;
                        r_ori     <= i_origin_index;
                        r_stride  <= stride_in;
                        r_has_top <= {1'b0, i_origin_index} >= stride_in;
                        r_rem     <= '0;
                        r_bit     <= 4'(hfe_pkg::ADDR_IN_W - 1);
                        r_acc     <= '0;
                        r_err     <= 1'b0;
                        r_state   <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_rem <= rem_next;
                    if (r_bit == 4'd0) begin
                        r_has_left <= (rem_next != '0);
                        r_k        <= '0;
                        r_state    <= S_TERM;
                    end else begin
                        r_bit <= r_bit - 4'd1;
                    end
                end
                S_TERM: begin
                    r_p1_valid <= term_active;
                    r_p1_idx   <= idx;
                    r_p1_wt    <= cur_term.wt;
                    r_k        <= r_k + hfe_pkg::K_W'(1);
                    if (r_k == K_LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_valid && !r_p2_valid) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_err ? '0 : sat_val;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // single port: a load never meets a corner read
    `HFE_NEVER(a_port_conflict, i_clk, i_rst_n, mem_we && rd_en, "write and read in one cycle")
    // read data arrives in the cycle after an address stage
    `HFE_ASSERT(a_p2_follows_p1, i_clk, i_rst_n, r_p2_valid |-> $past(r_p1_valid), "read without address stage")
    // accumulation only while the sequencer sums
    `HFE_ASSERT(a_p2_in_sum, i_clk, i_rst_n, r_p2_valid |-> (r_state == S_TERM || r_state == S_DRAIN), "accumulate outside summing")
    // partial remainder stays below the stride
    `HFE_ASSERT(a_rem_bound, i_clk, i_rst_n, (r_state == S_MOD) |-> (r_rem < r_stride), "remainder out of bound")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haar feature evaluation unit testbench
// Fills the integral-image store, then drives directed and random load and
// evaluate transfers across several row widths. Random gaps are used on both
// channels, plus one long output hold. Every result is checked against an
// in-order scoreboard fed by a behavioral corner-sum predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import hfe_pkg::*;

    localparam int MEM_DEPTH    = 4096;
    localparam int VALUE_BITS   = 24;
    localparam int EVAL_CYCLES  = 26;        // acceptance to next free slot
    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic                 op;
        logic [ADDR_IN_W-1:0] load_address;
        logic [LOAD_W-1:0]    load_value;
        logic [TYPE_W-1:0]    feature_type;
        logic [SPAN_W-1:0]    feature_w;
        logic [SPAN_W-1:0]    feature_h;
        logic [ADDR_IN_W-1:0] origin_index;
    } haar_item_t;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    err;
    } feature_result_t;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [ROW_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_operation;
    logic [ADDR_IN_W-1:0]    i_load_address;
    logic [LOAD_W-1:0]       i_load_value;
    logic [TYPE_W-1:0]       i_feature_type;
    logic [SPAN_W-1:0]       i_feature_w;
    logic [SPAN_W-1:0]       i_feature_h;
    logic [ADDR_IN_W-1:0]    i_origin_index;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [OUT_W-1:0] o_feature_value;
    logic                    o_address_error;

    haar_feature_eval_unit #(
        .MEM_DEPTH  (MEM_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_load_address  (i_load_address),
        .i_load_value    (i_load_value),
        .i_feature_type  (i_feature_type),
        .i_feature_w     (i_feature_w),
        .i_feature_h     (i_feature_h),
        .i_origin_index  (i_origin_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_feature_value (o_feature_value),
        .o_address_error (o_address_error)
    );

    // ------------------------------------------------------------------------
    // Predictor state: mirror of the store and the current stride
    // ------------------------------------------------------------------------
    logic [LOAD_W-1:0] image_copy [MEM_DEPTH];
    logic [ROW_W-1:0]  row_width_now;
    feature_result_t   pending_features [$];

    // shared knobs between the sender, the receiver and the tests
    bit          idle_on;         // 0 = back-to-back stretch on both sides
    logic        hold_pending;    // request one long output hold
    int unsigned hold_len;

    int cycle_count;
    int mismatches;
    int n_checked;
    int n_loads;
    int n_evals;
    int n_corner_err;
    int n_widths;
    int n_holds;

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_features.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Corner-sum predictor
    // ------------------------------------------------------------------------
    function automatic int span_offset(input t_off_code code, input int span);
        int r;
        case (code)
            OFF_FULL:  r = span;
            OFF_HALF:  r = span / 2;
            OFF_THIRD: r = span / 3;
            OFF_TWO3:  r = (2 * span) / 3;
            default:   r = -1;
        endcase
        return r;
    endfunction

    function automatic feature_result_t predict_feature(input haar_item_t it);
        t_off_code       xs [TERM_COUNT];
        t_off_code       ys [TERM_COUNT];
        int              ws [TERM_COUNT];
        int              stride;
        int              ori;
        int              idx;
        bit              has_top;
        bit              has_left;
        bit              err;
        longint          sum;
        feature_result_t r;

        xs = '{default: OFF_NEG};
        ys = '{default: OFF_NEG};
        ws = '{default: 0};
        case (it.feature_type)
            FT_HORIZ2: begin
                xs = '{OFF_HALF, OFF_FULL, OFF_FULL, OFF_HALF, OFF_NEG, OFF_NEG,
                       OFF_NEG, OFF_NEG, OFF_NEG};
                ys = '{OFF_FULL, OFF_FULL, OFF_NEG, OFF_NEG, OFF_FULL, OFF_NEG,
                       OFF_NEG, OFF_NEG, OFF_NEG};
                ws = '{2, -1, 1, -2, -1, 1, 0, 0, 0};
            end
            FT_HORIZ3: begin
                xs = '{OFF_FULL, OFF_TWO3, OFF_THIRD, OFF_FULL, OFF_TWO3, OFF_THIRD,
                       OFF_NEG, OFF_NEG, OFF_NEG};
                ys = '{OFF_FULL, OFF_FULL, OFF_FULL, OFF_NEG, OFF_NEG, OFF_NEG,
                       OFF_FULL, OFF_NEG, OFF_NEG};
                ws = '{1, -2, 2, -1, 2, -2, -1, 1, 0};
            end
            FT_VERT2: begin
                xs = '{OFF_FULL, OFF_FULL, OFF_FULL, OFF_NEG, OFF_NEG, OFF_NEG,
                       OFF_NEG, OFF_NEG, OFF_NEG};
                ys = '{OFF_HALF, OFF_FULL, OFF_NEG, OFF_FULL, OFF_HALF, OFF_NEG,
                       OFF_NEG, OFF_NEG, OFF_NEG};
                ws = '{2, -1, -1, 1, -2, 1, 0, 0, 0};
            end
            FT_VERT3: begin
                xs = '{OFF_FULL, OFF_FULL, OFF_FULL, OFF_NEG, OFF_NEG, OFF_NEG,
                       OFF_FULL, OFF_NEG, OFF_NEG};
                ys = '{OFF_FULL, OFF_TWO3, OFF_THIRD, OFF_FULL, OFF_TWO3, OFF_THIRD,
                       OFF_NEG, OFF_NEG, OFF_NEG};
                ws = '{1, -2, 2, -1, 2, -2, -1, 1, 0};
            end
            FT_CHECK: begin
                xs = '{OFF_FULL, OFF_HALF, OFF_FULL, OFF_HALF, OFF_NEG, OFF_NEG,
                       OFF_FULL, OFF_HALF, OFF_NEG};
                ys = '{OFF_FULL, OFF_FULL, OFF_HALF, OFF_HALF, OFF_FULL, OFF_HALF,
                       OFF_NEG, OFF_NEG, OFF_NEG};
                ws = '{1, -2, -2, 4, 1, -2, 1, -2, 1};
            end
            default: ;  // unknown type: no terms, zero result
        endcase

        stride   = (row_width_now == '0) ? 1 : int'(row_width_now);
        ori      = int'(it.origin_index);
        has_top  = ori >= stride;
        has_left = (ori % stride) != 0;
        err      = 1'b0;
        sum      = 0;
        for (int k = 0; k < TERM_COUNT; k++) begin
            if (ws[k] == 0) continue;
            if (ys[k] == OFF_NEG && !has_top) continue;
            if (xs[k] == OFF_NEG && !has_left) continue;
            idx = ori + span_offset(xs[k], int'(it.feature_w))
                + span_offset(ys[k], int'(it.feature_h)) * stride;
            if (idx >= MEM_DEPTH) begin
                err = 1'b1;
            end else begin
                sum += longint'(ws[k]) * longint'(image_copy[idx]);
            end
        end
        if (err) sum = 0;
        if (sum > OUT_MAX) sum = OUT_MAX;
        if (sum < OUT_MIN) sum = OUT_MIN;
        r.value = OUT_W'(sum);
        r.err   = err;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic haar_item_t load_item(input int addr, input logic [LOAD_W-1:0] val);
        haar_item_t it;
        it.op           = OP_LOAD;
        it.load_address = ADDR_IN_W'(addr);
        it.load_value   = val;
        it.feature_type = TYPE_W'($urandom);
        it.feature_w    = SPAN_W'($urandom);
        it.feature_h    = SPAN_W'($urandom);
        it.origin_index = ADDR_IN_W'($urandom);
        return it;
    endfunction

    function automatic haar_item_t eval_item(input logic [TYPE_W-1:0] ft, input int w,
                                             input int h, input int ori);
        haar_item_t it;
        it.op           = OP_EVAL;
        it.load_address = ADDR_IN_W'($urandom);
        it.load_value   = LOAD_W'($urandom);
        it.feature_type = ft;
        it.feature_w    = SPAN_W'(w);
        it.feature_h    = SPAN_W'(h);
        it.origin_index = ADDR_IN_W'(ori);
        return it;
    endfunction

    // Mostly features that fit the store at the current stride, the rest
    // fully random fields (often reaching past the end of the store).
    function automatic haar_item_t random_item();
        haar_item_t it;
        int         stride;
        int         reach;
        int         sel;

        it = eval_item(FT_HORIZ2, 0, 0, 0);
        it.op = ($urandom_range(0, 9) < 3) ? OP_LOAD : OP_EVAL;
        case ($urandom_range(0, 9))
            0:       it.load_value = '1;
            1:       it.load_value = '0;
            default: it.load_value = LOAD_W'($urandom);
        endcase
        sel = $urandom_range(0, 7);
        if (sel == 0)      it.feature_type = TYPE_W'(0);
        else if (sel == 1) it.feature_type = TYPE_W'($urandom_range(6, 7));
        else               it.feature_type = TYPE_W'($urandom_range(1, 5));
        it.feature_w = ($urandom_range(0, 1) != 0) ? SPAN_W'($urandom_range(0, 15))
                                                   : SPAN_W'($urandom);
        it.feature_h = ($urandom_range(0, 1) != 0) ? SPAN_W'($urandom_range(0, 7))
                                                   : SPAN_W'($urandom);
        stride = (row_width_now == '0) ? 1 : int'(row_width_now);
        reach  = int'(it.feature_w) + int'(it.feature_h) * stride;
        if ($urandom_range(0, 4) != 0 && reach <= MEM_DEPTH - 1)
            it.origin_index = ADDR_IN_W'($urandom_range(0, MEM_DEPTH - 1 - reach));
        else
            it.origin_index = ADDR_IN_W'($urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: one transfer per call. Valid stays high into the next
    // call when no gap is drawn, so back-to-back transfers are possible.
    // ------------------------------------------------------------------------
    task automatic send_item(input haar_item_t it);
        int unsigned     gap;
        feature_result_t r;

        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= it.op;
        i_load_address <= it.load_address;
        i_load_value   <= it.load_value;
        i_feature_type <= it.feature_type;
        i_feature_w    <= it.feature_w;
        i_feature_h    <= it.feature_h;
        i_origin_index <= it.origin_index;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));

        // transfer taken at this edge: update the mirror or queue a result
        if (it.op == OP_LOAD) begin
            image_copy[it.load_address] = it.load_value;
            n_loads++;
        end else begin
            r = predict_feature(it);
            if (r.err) n_corner_err++;
            pending_features.push_back(r);
            n_evals++;
        end
    endtask

    // Drop valid, let every queued result drain, then give the sequencer time
    // to finish anything that produces no result.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_features.size() != 0) @(posedge i_clk);
        repeat (2 * EVAL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_row_width(input logic [ROW_W-1:0] rw);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rw;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid   <= 1'b0;
        row_width_now = rw;
        n_widths++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: per-result random stall, plus one long hold on request.
    // ------------------------------------------------------------------------
    int unsigned rx_left;

    always @(posedge i_clk) begin : rx_ctl
        int unsigned gap;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_left = 0;
        end else if (i_out_stall) begin
            if (rx_left <= 1) begin
                rx_left = 0;
                i_out_stall <= 1'b0;
            end else begin
                rx_left--;
            end
        end else begin
            gap = 0;
            if (o_out_valid) gap = idle_on ? $urandom_range(0, 10) : 0;
            if (hold_pending) begin
                gap = hold_len;
                hold_pending <= 1'b0;
                n_holds++;
            end
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                rx_left = gap;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: in-order compare against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void report_mismatch(input string what, input longint want,
                                            input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0d] mismatch on %s: expected %0d, actual %0d",
                     cycle_count, what, want, got);
    endfunction

    always @(posedge i_clk) begin : result_check
        feature_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_features.size() == 0) begin
                report_mismatch("result with nothing outstanding", 0, o_feature_value);
            end else begin
                want = pending_features.pop_front();
                n_checked++;
                if (o_feature_value !== want.value)
                    report_mismatch("feature_value", want.value, o_feature_value);
                if (o_address_error !== want.err)
                    report_mismatch("address_error", want.err, o_address_error);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every entry gets a word before any evaluation reads it.
    task automatic test_fill_store();
        idle_on = 1'b0;
        for (int a = 0; a < MEM_DEPTH; a++) begin
            if (a == 0)                  send_item(load_item(a, '0));
            else if (a == MEM_DEPTH - 1) send_item(load_item(a, '1));
            else                         send_item(load_item(a, LOAD_W'($urandom)));
        end
    endtask

    // Boundary handling, each feature type, unknown types, saturation-size sums
    // and corners past the end of the store, at the reset stride of 64.
    task automatic test_directed_corners();
        idle_on = 1'b1;
        // checkerboard with the weight-4 corner at full scale, then the
        // negative corners at full scale
        send_item(load_item(65, '1));
        send_item(load_item(66, '0));
        send_item(load_item(129, '0));
        send_item(load_item(130, '0));
        send_item(eval_item(FT_CHECK, 2, 2, 0));
        send_item(load_item(65, '0));
        send_item(load_item(66, '1));
        send_item(load_item(129, '1));
        send_item(eval_item(FT_CHECK, 2, 2, 0));
        // interior origin: both the row above and the left column exist
        send_item(eval_item(FT_HORIZ2, 12, 9, 197));
        send_item(eval_item(FT_HORIZ3, 12, 9, 197));
        send_item(eval_item(FT_VERT2, 12, 9, 197));
        send_item(eval_item(FT_VERT3, 12, 9, 197));
        send_item(eval_item(FT_CHECK, 12, 9, 197));
        // top-left origin, first row with a left column, first column lower down
        send_item(eval_item(FT_VERT2, 63, 0, 0));
        send_item(eval_item(FT_HORIZ3, 0, 63, 5));
        send_item(eval_item(FT_VERT3, 63, 30, 128));
        // unknown feature types
        send_item(eval_item(TYPE_W'(0), 5, 5, 300));
        send_item(eval_item(TYPE_W'(6), 5, 5, 300));
        send_item(eval_item(TYPE_W'(7), 63, 63, 4095));
        // last entry just fits, one past it does not
        send_item(eval_item(FT_HORIZ2, 63, 0, 4032));
        send_item(eval_item(FT_HORIZ2, 63, 0, 4033));
        send_item(eval_item(FT_CHECK, 63, 63, 4095));
    endtask

    // Stride extremes: zero acts as one, a single column, the full row of 4096
    // and the largest value the register holds.
    task automatic test_row_width_extremes();
        logic [ROW_W-1:0] widths [5];
        widths = '{13'd0, 13'd1, 13'd4096, 13'd8191, ROW_W'($urandom_range(1, 4096))};
        foreach (widths[i]) begin
            set_row_width(widths[i]);
            idle_on = 1'b1;
            repeat (12) send_item(random_item());
            send_item(eval_item(FT_CHECK, $urandom_range(0, 63), 0, $urandom));
        end
        set_row_width(ROW_WIDTH_RESET);
    endtask

    // Receiver holds off for a long stretch while evaluations keep coming, so
    // the output register and the sequencer fill and the input stalls.
    task automatic test_output_backpressure();
        wait_idle();
        idle_on      = 1'b0;
        hold_len     = 400;
        hold_pending <= 1'b1;
        @(posedge i_clk);
        repeat (12) send_item(eval_item(TYPE_W'($urandom_range(1, 5)),
                                        $urandom_range(0, 15), $urandom_range(0, 7),
                                        $urandom_range(0, 3000)));
        wait_idle();
    endtask

    task automatic test_random_mix();
        logic [ROW_W-1:0] rw;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 3))
                0: begin
                    case ($urandom_range(0, 3))
                        0:       rw = 13'd0;
                        1:       rw = 13'd1;
                        2:       rw = 13'd4096;
                        default: rw = 13'd8191;
                    endcase
                end
                1:       rw = ROW_W'($urandom_range(1, 4096));
                default: rw = ROW_W'($urandom_range(1, 128));
            endcase
            set_row_width(rw);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
                send_item(random_item());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_operation    <= OP_LOAD;
        i_load_address <= '0;
        i_load_value   <= '0;
        i_feature_type <= '0;
        i_feature_w    <= '0;
        i_feature_h    <= '0;
        i_origin_index <= '0;
        hold_pending   <= 1'b0;
        hold_len       = 0;
        idle_on        = 1'b1;
        row_width_now  = ROW_WIDTH_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_store();
        test_directed_corners();
        test_row_width_extremes();
        test_output_backpressure();
        test_random_mix();

        wait_idle();
        $display("covered %0d loads and %0d feature evaluations (%0d past the store)",
                 n_loads, n_evals, n_corner_err);
        $display("%0d row widths, %0d long output holds, %0d results checked, %0d mismatches",
                 n_widths, n_holds, n_checked, mismatches);
        if (mismatches == 0 && pending_features.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
